@@ sv/mfpr_pkg.sv @@
// Shared constants, types and helpers for the framebuffer page rotator.
`timescale 1ns / 1ps
package mfpr_pkg;

   // Panel geometry
   localparam int COLUMNS     = 128;
   localparam int PANEL_ROWS  = 32;
   localparam int RAM_ROWS    = 64;

   localparam int ROW_BYTES   = COLUMNS / 8;
   localparam int PANEL_PAGES = PANEL_ROWS / 8;
   localparam int RAM_PAGES   = RAM_ROWS / 8;
   localparam int DATA_BYTES  = COLUMNS * RAM_PAGES;
   localparam int CMD_BYTES   = 3;

   localparam int ROW_BITS    = $clog2(ROW_BYTES);
   localparam int PAGE_BITS   = $clog2(PANEL_PAGES);
   localparam int RPAGE_BITS  = $clog2(RAM_PAGES);
   localparam int COL_BITS    = $clog2(COLUMNS);
   localparam int ADDR_W      = PAGE_BITS + ROW_BITS;
   localparam int ENTRIES     = PANEL_PAGES * ROW_BYTES;
   localparam int WORD_W      = 64;
   localparam int POS_W       = $clog2(DATA_BYTES + CMD_BYTES + 1);
   localparam int DATA_W      = $clog2(DATA_BYTES);

   // Field widths
   localparam int INDEX_W     = 9;
   localparam int PIX_W       = 8;
   localparam int REQ_DATA_W  = 24;

   // Request codes
   localparam logic [1:0] REQ_STORE = 2'd0;
   localparam logic [1:0] REQ_START = 2'd1;
   localparam logic [1:0] REQ_TICK  = 2'd2;

   // Flush preamble bytes
   localparam logic [7:0] CMD_BYTE0 = 8'h04;
   localparam logic [7:0] CMD_BYTE1 = 8'h10;
   localparam logic [7:0] CMD_BYTE2 = 8'h40;

   typedef struct packed {
      logic store_rd;
      logic store_wr;
      logic start;
      logic tick_rd;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic flushing;
      logic out_valid;
   } status_type;

   function automatic logic [7:0] flush_cmd(input logic [1:0] sel);
      logic [7:0] b;
      case (sel)
         2'd0:    b = CMD_BYTE0;
         2'd1:    b = CMD_BYTE1;
         default: b = CMD_BYTE2;
      endcase
      return b;
   endfunction

endpackage

@@ sv/mono_framebuffer_page_rotator_unit.sv @@
// Top level of the monochrome framebuffer page rotator.
// Usage:
//   Request beats on req_*: tuser selects store (pixel byte at byte_index),
//   flush start or flush tick; code 3 is dropped. Each tick during a flush
//   yields one response beat on rsp_*: three command bytes, then 1024 data
//   bytes column by column, tlast on the final data byte.
//   Steps: a store is one read and then one write of the single-port page
//   store (one 64-bit word per pixel byte); a start, an idle tick or an unused
//   code is handled in the idle state alone; a flush tick reads the store, then
//   waits, if need be, for the output register to drain and loads the response.
//   The next request is taken while a response still sits in the output
//   register. A stalled receiver holds the response; a further tick is still
//   taken, then req_tready stays low until the register frees.
//   Reset: synchronous, active high. The page store reads as zero after reset
//   (per-entry valid flags), no clearing pass; flush stops and rewinds.
`timescale 1ns / 1ps
module mono_framebuffer_page_rotator_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [8:0] byte_index, [16:9] pixel_byte, [23:17] zero
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic [0:0]  rsp_tuser,   // [0] is_command
   output logic        rsp_tlast
);
   import mfpr_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       rsp_command;

   mfpr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mfpr_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .byte_index  (req_tdata[INDEX_W-1:0]),
      .pixel_byte  (req_tdata[INDEX_W +: PIX_W]),
      .cmd         (cmd),
      .status      (status),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_byte    (rsp_tdata),
      .rsp_command (rsp_command),
      .rsp_last    (rsp_tlast)
   );

   assign rsp_tuser[0] = rsp_command;

   // a new response never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_tvalid || rsp_tready))
      else $error("response register overwritten");

   // store write always follows its read in the next cycle
   a_store_rmw: assert property (@(posedge clock) disable iff (reset)
      cmd.store_rd |=> cmd.store_wr)
      else $error("store read not followed by write");

   // final beat is a data byte, and the flush ends with it
   a_last_data: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && status.flushing) ##1 (rsp_tvalid && rsp_tlast) |-> !rsp_command
         && !status.flushing)
      else $error("last beat marked as command or flush still running");

   // a tick taken during a flush blocks requests until its byte is loaded
   a_tick_blocks: assert property (@(posedge clock) disable iff (reset)
      cmd.tick_rd |=> !req_tready)
      else $error("request taken while a flush byte is pending");

endmodule

@@ sv/mfpr_ctrl.sv @@
// Sequencer for store, flush start and flush tick requests.
`timescale 1ns / 1ps
module mfpr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [1:0]           req_tuser,
   input  logic                 rsp_tready,
   input  mfpr_pkg::status_type status,
   output mfpr_pkg::cmd_type    cmd
);
   import mfpr_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_STORE = 3'b010,
      ST_EMIT  = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               case (req_tuser)
                  REQ_STORE: begin
                     cmd.store_rd = 1'b1;
                     state_in     = ST_STORE;
                  end
                  REQ_START: cmd.start = 1'b1;
                  REQ_TICK: begin
                     if (status.flushing) begin
                        cmd.tick_rd = 1'b1;
                        state_in    = ST_EMIT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_STORE: begin
            cmd.store_wr = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_EMIT: begin
            // wait until the output register is free or being drained
            if (!status.out_valid || rsp_tready) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ sv/mfpr_datapath.sv @@
// Rotated page store, flush position counter and output register.
`timescale 1ns / 1ps
module mfpr_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [mfpr_pkg::INDEX_W-1:0]  byte_index,
   input  logic [mfpr_pkg::PIX_W-1:0]    pixel_byte,
   input  mfpr_pkg::cmd_type             cmd,
   output mfpr_pkg::status_type          status,
   input  logic                          rsp_tready,
   output logic                          rsp_tvalid,
   output logic [7:0]                    rsp_byte,
   output logic                          rsp_command,
   output logic                          rsp_last
);
   import mfpr_pkg::*;

   // One entry per (page slot, 8-column group): byte b holds column 8*group+b
   logic [WORD_W-1:0] mem [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;

   logic [INDEX_W-1:0] idx_ff;
   logic [PIX_W-1:0]   pix_ff;
   logic [WORD_W-1:0]  rd_ff;
   logic               rd_valid_ff;

   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               flushing_ff, flushing_in;

   logic               out_valid_ff, out_valid_in;
   logic [7:0]         out_byte_ff, out_byte_in;
   logic               out_cmd_ff, out_cmd_in;
   logic               out_last_ff, out_last_in;

   logic [ADDR_W-1:0]  store_addr_in, store_addr_ff, flush_addr, rd_addr;
   logic [POS_W-1:0]   data_pos;
   logic [DATA_W-1:0]  d;
   logic [COL_BITS-1:0] col;
   logic [RPAGE_BITS-1:0] slot;
   logic [WORD_W-1:0]  rd_word, wr_word;
   logic [2:0]         bitno;

   // slot = PANEL_PAGES-1 - y/8, group = x/8
   assign store_addr_in = {~byte_index[INDEX_W-1 -: PAGE_BITS], byte_index[ROW_BITS-1:0]};
   assign store_addr_ff = {~idx_ff[INDEX_W-1 -: PAGE_BITS], idx_ff[ROW_BITS-1:0]};

   assign data_pos   = pos_ff - POS_W'(CMD_BYTES);
   assign d          = data_pos[DATA_W-1:0];
   assign slot       = d[RPAGE_BITS-1:0];
   assign col        = d[DATA_W-1 -: COL_BITS];
   assign flush_addr = {slot[PAGE_BITS-1:0], col[COL_BITS-1 -: ROW_BITS]};
   assign rd_addr    = cmd.store_rd ? store_addr_in : flush_addr;

   assign rd_word = rd_valid_ff ? rd_ff : '0;
   assign bitno   = ~idx_ff[6:4];

   always_comb begin
      wr_word = rd_word;
      for (int b = 0; b < 8; b++) begin
         wr_word[8*b + int'(bitno)] = pix_ff[7-b];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store_rd) begin
         idx_ff <= byte_index;
         pix_ff <= pixel_byte;
      end
      if (cmd.store_rd || cmd.tick_rd) begin
         rd_ff       <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
      if (cmd.store_wr) begin
         mem[store_addr_ff] <= wr_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.store_wr) begin
         valid_ff[store_addr_ff] <= 1'b1;
      end
   end

   always_comb begin
      pos_in       = pos_ff;
      flushing_in  = flushing_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_byte_in  = out_byte_ff;
      out_cmd_in   = out_cmd_ff;
      out_last_in  = out_last_ff;
      if (cmd.start) begin
         flushing_in = 1'b1;
         pos_in      = '0;
      end else if (cmd.emit) begin
         out_valid_in = 1'b1;
         if (pos_ff < POS_W'(CMD_BYTES)) begin
            out_byte_in = flush_cmd(pos_ff[1:0]);
            out_cmd_in  = 1'b1;
            out_last_in = 1'b0;
            pos_in      = pos_ff + 1'b1;
         end else begin
            out_cmd_in  = 1'b0;
            out_byte_in = (int'(slot) >= PANEL_PAGES) ? 8'h00 : rd_word[8*col[2:0] +: 8];
            if (d == DATA_W'(DATA_BYTES - 1)) begin
               out_last_in = 1'b1;
               flushing_in = 1'b0;
               pos_in      = '0;
            end else begin
               out_last_in = 1'b0;
               pos_in      = pos_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         flushing_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         flushing_ff  <= flushing_in;
         out_valid_ff <= out_valid_in;
      end
      out_byte_ff <= out_byte_in;
      out_cmd_ff  <= out_cmd_in;
      out_last_ff <= out_last_in;
   end

   assign status.flushing  = flushing_ff;
   assign status.out_valid = out_valid_ff;
   assign rsp_tvalid  = out_valid_ff;
   assign rsp_byte    = out_byte_ff;
   assign rsp_command = out_cmd_ff;
   assign rsp_last    = out_last_ff;

endmodule

@@ tb/sv/tb_mono_framebuffer_page_rotator_unit.sv @@
// Testbench for the framebuffer page rotator: directed table, random traffic, self-checking.
`timescale 1ns / 1ps
module tb_mono_framebuffer_page_rotator_unit;
   import mfpr_pkg::*;

   localparam logic [1:0] REQ_UNUSED  = 2'd3;
   localparam int         STORE_BYTES = COLUMNS * PANEL_PAGES;
   localparam int         FLUSH_BEATS = CMD_BYTES + DATA_BYTES;
   localparam int         HOLD_CYCLES = 300;
   localparam int         DRAIN_CYCLES = 16;
   localparam int         CYCLE_LIMIT = 200000;
   localparam int         N_DIRECTED  = 25;

   typedef struct packed {
      logic [7:0] data;
      logic       cmd;
      logic       fin;
   } panel_beat_type;

   typedef enum logic [1:0] {RSP_NONE, RSP_FIXED, RSP_MODEL} rsp_src_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [8:0]  idx;
      logic [7:0]  pix;
      rsp_src_type src;
      logic [7:0]  data;
      logic        cmd;
      logic        fin;
   } dir_row_type;

   // fixed rows: idle tick, command preamble, zero store after reset, upper slots
   localparam dir_row_type DIRECTED [N_DIRECTED] = '{
      '{REQ_TICK,   9'd0,   8'h00, RSP_NONE,  8'h00,     1'b0, 1'b0},
      '{REQ_UNUSED, 9'h1FF, 8'hFF, RSP_NONE,  8'h00,     1'b0, 1'b0},
      '{REQ_START,  9'd0,   8'h00, RSP_NONE,  8'h00,     1'b0, 1'b0},
      '{REQ_TICK,   9'd0,   8'h00, RSP_FIXED, CMD_BYTE0, 1'b1, 1'b0},
      '{REQ_TICK,   9'd0,   8'h00, RSP_FIXED, CMD_BYTE1, 1'b1, 1'b0},
      '{REQ_TICK,   9'd0,   8'h00, RSP_FIXED, CMD_BYTE2, 1'b1, 1'b0},
      '{REQ_TICK,   9'd0,   8'h00, RSP_FIXED, 8'h00,     1'b0, 1'b0},
      '{REQ_STORE,  9'd0,   8'hFF, RSP_NONE,  8'h00,     1'b0, 1'b0},
      '{REQ_STORE,  9'd511, 8'hFF, RSP_NONE,  8'h00,     1'b0, 1'b0},
      '{REQ_STORE,  9'd496, 8'hAA, RSP_NONE,  8'h00,     1'b0, 1'b0},
      '{REQ_STORE,  9'd15,  8'h01, RSP_NONE,  8'h00,     1'b0, 1'b0},
      '{REQ_STORE,  9'd256, 8'h00, RSP_NONE,  8'h00,     1'b0, 1'b0},
      '{REQ_STORE,  9'h155, 8'h5A, RSP_NONE,  8'h00,     1'b0, 1'b0},
      '{REQ_TICK,   9'd0,   8'h00, RSP_MODEL, 8'h00,     1'b0, 1'b0},
      '{REQ_TICK,   9'd0,   8'h00, RSP_MODEL, 8'h00,     1'b0, 1'b0},
      '{REQ_TICK,   9'd0,   8'h00, RSP_MODEL, 8'h00,     1'b0, 1'b0},
      '{REQ_TICK,   9'd0,   8'h00, RSP_FIXED, 8'h00,     1'b0, 1'b0},
      '{REQ_START,  9'd0,   8'h00, RSP_NONE,  8'h00,     1'b0, 1'b0},
      '{REQ_TICK,   9'd0,   8'h00, RSP_FIXED, CMD_BYTE0, 1'b1, 1'b0},
      '{REQ_UNUSED, 9'd0,   8'h00, RSP_NONE,  8'h00,     1'b0, 1'b0},
      '{REQ_TICK,   9'd0,   8'h00, RSP_FIXED, CMD_BYTE1, 1'b1, 1'b0},
      '{REQ_STORE,  9'h0AA, 8'h3C, RSP_NONE,  8'h00,     1'b0, 1'b0},
      '{REQ_TICK,   9'd0,   8'h00, RSP_FIXED, CMD_BYTE2, 1'b1, 1'b0},
      '{REQ_TICK,   9'd0,   8'h00, RSP_MODEL, 8'h00,     1'b0, 1'b0},
      '{REQ_TICK,   9'd0,   8'h00, RSP_MODEL, 8'h00,     1'b0, 1'b0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // [8:0] byte_index, [16:9] pixel_byte, [23:17] zero
   logic [1:0]  req_tuser = '0;   // [1:0] req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // [7:0] out_byte
   logic [0:0]  rsp_tuser;        // [0] is_command
   logic        rsp_tlast;

   // predictor state
   logic [7:0]  page_img [STORE_BYTES];
   int unsigned stream_pos;
   bit          streaming;

   panel_beat_type pending_panel_bytes [$];
   int          fault_count = 0;
   int          cycle_count = 0;
   int          idle_pct = 36;
   int          hold_asks = 0;
   int          hold_seen = 0;
   int          hold_left = 0;

   mono_framebuffer_page_rotator_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_mono_framebuffer_page_rotator_unit: done, errors");
         $finish;
      end
   end

   // Rotates stored bytes into the page image and walks the flush stream.
   function automatic logic panel_step(input logic [1:0] kind, input logic [8:0] idx,
                                       input logic [7:0] pix, output panel_beat_type beat);
      int unsigned row, xbase, slot, bitno, d, col, rslot;
      beat = '0;
      panel_step = 1'b0;
      case (kind)
         REQ_STORE: begin
            if (idx < STORE_BYTES) begin
               row   = idx / ROW_BYTES;
               xbase = (idx % ROW_BYTES) * 8;
               slot  = PANEL_PAGES - 1 - row / 8;
               bitno = 7 - row % 8;
               for (int b = 0; b < 8; b++)
                  page_img[(xbase + b) * PANEL_PAGES + slot][bitno] = pix[7 - b];
            end
         end
         REQ_START: begin
            streaming  = 1'b1;
            stream_pos = 0;
         end
         REQ_TICK: begin
            if (streaming) begin
               panel_step = 1'b1;
               if (stream_pos < CMD_BYTES) begin
                  beat.cmd  = 1'b1;
                  beat.data = (stream_pos == 0) ? CMD_BYTE0 :
                              (stream_pos == 1) ? CMD_BYTE1 : CMD_BYTE2;
                  stream_pos++;
               end else begin
                  d     = stream_pos - CMD_BYTES;
                  col   = d / RAM_PAGES;
                  rslot = d % RAM_PAGES;
                  // slots beyond the panel height carry no pixels
                  beat.data = (rslot < PANEL_PAGES) ? page_img[col * PANEL_PAGES + rslot] : 8'h00;
                  if (d + 1 >= DATA_BYTES) begin
                     beat.fin   = 1'b1;
                     streaming  = 1'b0;
                     stream_pos = 0;
                  end else begin
                     stream_pos++;
                  end
               end
            end
         end
         default: ;
      endcase
   endfunction

   task automatic send_beat(input logic [1:0] kind, input logic [8:0] idx,
                            input logic [7:0] pix, output logic made,
                            output panel_beat_type beat);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {7'd0, pix, idx};
      do @(posedge clock); while (!req_tready);
      made = panel_step(kind, idx, pix, beat);
   endtask

   task automatic feed(input logic [1:0] kind, input logic [8:0] idx, input logic [7:0] pix);
      logic           made;
      panel_beat_type beat;
      send_beat(kind, idx, pix, made, beat);
      if (made)
         pending_panel_bytes.push_back(beat);
   endtask

   task automatic feed_random(input int store_pct, input int tick_pct, input int start_pct);
      int r;
      r = $urandom_range(99);
      if (r < store_pct)
         feed(REQ_STORE, 9'($urandom_range(511)), 8'($urandom_range(255)));
      else if (r < store_pct + tick_pct)
         feed(REQ_TICK, 9'($urandom_range(511)), 8'($urandom_range(255)));
      else if (r < store_pct + tick_pct + start_pct)
         feed(REQ_START, 9'($urandom_range(511)), 8'($urandom_range(255)));
      else
         feed(REQ_UNUSED, 9'($urandom_range(511)), 8'($urandom_range(255)));
   endtask

   task automatic check_rsp;
      panel_beat_type want;
      if (pending_panel_bytes.size() == 0) begin
         fault_count++;
         $display("%0t: unexpected beat: expected none, actual byte %02h cmd %0d last %0d",
                  $time, rsp_tdata, rsp_tuser[0], rsp_tlast);
      end else begin
         want = pending_panel_bytes.pop_front();
         if (rsp_tdata !== want.data) begin
            fault_count++;
            $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                     $time, want.data, rsp_tdata);
         end
         if (rsp_tuser[0] !== want.cmd) begin
            fault_count++;
            $display("%0t: is_command mismatch: expected %0d, actual %0d",
                     $time, want.cmd, rsp_tuser[0]);
         end
         if (rsp_tlast !== want.fin) begin
            fault_count++;
            $display("%0t: last mismatch: expected %0d, actual %0d",
                     $time, want.fin, rsp_tlast);
         end
      end
   endtask

   // receiver: random backpressure plus long hold-offs on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_rsp();
         if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= idle_pct);
         end
      end
   end

   initial begin
      logic           made;
      panel_beat_type beat;
      panel_beat_type fixed;
      for (int i = 0; i < STORE_BYTES; i++)
         page_img[i] = 8'h00;
      streaming  = 1'b0;
      stream_pos = 0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < N_DIRECTED; i++) begin
         send_beat(DIRECTED[i].kind, DIRECTED[i].idx, DIRECTED[i].pix, made, beat);
         if (DIRECTED[i].src == RSP_FIXED) begin
            fixed.data = DIRECTED[i].data;
            fixed.cmd  = DIRECTED[i].cmd;
            fixed.fin  = DIRECTED[i].fin;
            pending_panel_bytes.push_back(fixed);
         end else if (DIRECTED[i].src == RSP_MODEL && made) begin
            pending_panel_bytes.push_back(beat);
         end
      end

      // mixed traffic, with a stretch of no idling on either side
      for (int i = 0; i < 80; i++) begin
         if (i == 20)
            idle_pct <= 0;
         if (i == 60)
            idle_pct <= 36;
         feed_random(55, 30, 7);
      end

      // one complete flush with stores interleaved, and a long receiver hold-off
      feed(REQ_START, 9'($urandom_range(511)), 8'($urandom_range(255)));
      for (int t = 0; t < FLUSH_BEATS; t++) begin
         if (t == 60)
            hold_asks <= hold_asks + 1;
         if ($urandom_range(99) < 3)
            feed(REQ_STORE, 9'($urandom_range(511)), 8'($urandom_range(255)));
         feed(REQ_TICK, 9'($urandom_range(511)), 8'($urandom_range(255)));
      end

      for (int i = 0; i < 40; i++)
         feed_random(45, 45, 3);

      req_tvalid <= 1'b0;
      while (pending_panel_bytes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fault_count == 0 && pending_panel_bytes.size() == 0) begin
         $display("tb_mono_framebuffer_page_rotator_unit: done, clean");
      end else begin
         $display("tb_mono_framebuffer_page_rotator_unit: done, errors");
      end
      $finish;
   end

endmodule

@@ files.f @@
sv/mfpr_pkg.sv
sv/mfpr_ctrl.sv
sv/mfpr_datapath.sv
sv/mono_framebuffer_page_rotator_unit.sv
tb/sv/tb_mono_framebuffer_page_rotator_unit.sv
